FILE: rtl/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types and constants for the string escape decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int CHAR_W      = 8;
  localparam int MODE_W      = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ESCAPE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HEX    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OCTAL  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DONE   = 3'd4;

  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_BSL   = 8'h5c;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } dec_t;

endpackage

FILE: rtl/sed_decode.sv
// ----------------------------------------------------------------------------
// sed_decode
// Escape decoding step: mode and run value registers plus the next-state
// logic, giving up to two result beats for the current input beat.
// ----------------------------------------------------------------------------
module sed_decode (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [sed_pkg::CHAR_W-1:0] char_code,
  input  logic                       first,
  output sed_pkg::dec_t              dec
);

  logic [sed_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [sed_pkg::CHAR_W-1:0] val_r, val_nxt;
  logic [sed_pkg::MODE_W-1:0] mode_eff;
  logic [sed_pkg::CHAR_W-1:0] val_eff;

  logic                       p_emit;
  sed_pkg::res_t              p_res;
  logic [sed_pkg::MODE_W-1:0] p_mode;

  logic                       is_oct;
  logic                       is_hex;
  logic [3:0]                 hex_d;
  logic [sed_pkg::CHAR_W-1:0] esc_ch;

  assign mode_eff = first ? sed_pkg::MODE_NORMAL : mode_r;
  assign val_eff  = first ? '0 : val_r;

  assign is_oct = (char_code >= 8'h30) && (char_code <= 8'h37);

  always_comb begin
    is_hex = 1'b1;
    hex_d  = char_code[3:0];
    if ((char_code >= 8'h30) && (char_code <= 8'h39)) begin
      hex_d = char_code[3:0];
    end else if (((char_code >= 8'h61) && (char_code <= 8'h66)) ||
                 ((char_code >= 8'h41) && (char_code <= 8'h46))) begin
      hex_d = char_code[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    case (char_code)
      8'h74:   esc_ch = 8'h09;
      8'h76:   esc_ch = 8'h0b;
      8'h6e:   esc_ch = 8'h0a;
      8'h72:   esc_ch = 8'h0d;
      8'h66:   esc_ch = 8'h0c;
      8'h61:   esc_ch = 8'h07;
      8'h62:   esc_ch = 8'h08;
      default: esc_ch = char_code;
    endcase
  end

  // plain byte handling, shared by normal mode and the end of a run
  always_comb begin
    p_emit      = 1'b1;
    p_res.ch    = char_code;
    p_res.last  = 1'b0;
    p_mode      = sed_pkg::MODE_NORMAL;
    if (char_code == sed_pkg::CH_QUOTE) begin
      p_res.ch   = sed_pkg::CH_NUL;
      p_res.last = 1'b1;
      p_mode     = sed_pkg::MODE_DONE;
    end else if (char_code == sed_pkg::CH_BSL) begin
      p_emit = 1'b0;
      p_mode = sed_pkg::MODE_ESCAPE;
    end
  end

  always_comb begin
    dec.n   = 2'd0;
    dec.r0  = p_res;
    dec.r1  = p_res;
    mode_nxt = mode_eff;
    val_nxt  = val_eff;
    case (mode_eff)
      sed_pkg::MODE_NORMAL: begin
        dec.n    = {1'b0, p_emit};
        mode_nxt = p_mode;
      end
      sed_pkg::MODE_ESCAPE: begin
        if (char_code == sed_pkg::CH_X) begin
          val_nxt  = '0;
          mode_nxt = sed_pkg::MODE_HEX;
        end else if (is_oct) begin
          val_nxt  = {5'd0, char_code[2:0]};
          mode_nxt = sed_pkg::MODE_OCTAL;
        end else begin
          dec.n       = 2'd1;
          dec.r0.ch   = esc_ch;
          dec.r0.last = 1'b0;
          mode_nxt    = sed_pkg::MODE_NORMAL;
        end
      end
      sed_pkg::MODE_HEX, sed_pkg::MODE_OCTAL: begin
        if ((mode_eff == sed_pkg::MODE_HEX) && is_hex) begin
          val_nxt = {val_eff[3:0], hex_d};
        end else if ((mode_eff == sed_pkg::MODE_OCTAL) && is_oct) begin
          val_nxt = {val_eff[4:0], char_code[2:0]};
        end else begin
          dec.n       = p_emit ? 2'd2 : 2'd1;
          dec.r0.ch   = val_eff;
          dec.r0.last = 1'b0;
          mode_nxt    = p_mode;
        end
      end
      default: begin
        dec.n = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sed_pkg::MODE_NORMAL;
      val_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      val_r  <= val_nxt;
    end
  end

endmodule

FILE: rtl/sed_outq.sv
// ----------------------------------------------------------------------------
// sed_outq
// Result queue: takes up to two result beats per cycle, hands out one unless stalled.
// ----------------------------------------------------------------------------
module sed_outq #(
  parameter int DEPTH = sed_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  sed_pkg::dec_t              dec,
  output logic                       room,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sed_pkg::CHAR_W-1:0] out_char,
  output logic                       out_last
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

  sed_pkg::res_t q_r [DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [PTR_W-1:0] tail_p1;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       n_in;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_MAX) ? '0 : p + 1'b1;
  endfunction

  assign room      = cnt_r <= CNT_W'(DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_char  = q_r[head_r].ch;
  assign out_last  = q_r[head_r].last;
  assign pop       = out_valid && !out_stall;
  assign n_in      = push ? dec.n : 2'd0;
  assign tail_p1   = ptr_inc(tail_r);

  always_comb begin
    head_nxt = pop ? ptr_inc(head_r) : head_r;
    case (n_in)
      2'd1:    tail_nxt = tail_p1;
      2'd2:    tail_nxt = ptr_inc(tail_p1);
      default: tail_nxt = tail_r;
    endcase
    cnt_nxt = cnt_r + CNT_W'(n_in) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      q_r[tail_r] <= dec.r0;
    end
    if (n_in == 2'd2) begin
      q_r[tail_p1] <= dec.r1;
    end
  end

endmodule

FILE: rtl/string_escape_decoder.sv
// ----------------------------------------------------------------------------
// string_escape_decoder
// Decodes the body of a quoted string literal, one raw byte per beat.
//
//   channel | ports                          | beat
//   in      | in_char_code, in_first         | one raw byte
//   out     | out_char, out_last             | one decoded byte
//
// One input beat per cycle unless stalled; mode and results are registered.
// A byte ending a hex or octal run can give two result beats; the output
// drains one per cycle unless stalled, so input stalls while the result queue
// lacks room for two. Synchronous active-low reset empties the queue, mode to normal.
// ----------------------------------------------------------------------------
module string_escape_decoder #(
  parameter int QDEPTH = sed_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [sed_pkg::CHAR_W-1:0] in_char_code,
  input  logic                       in_first,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sed_pkg::CHAR_W-1:0] out_char,
  output logic                       out_last
);

  logic          room;
  logic          accept;
  sed_pkg::dec_t dec;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  sed_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .char_code (in_char_code),
    .first     (in_first),
    .dec       (dec)
  );

  sed_outq #(
    .DEPTH (QDEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .dec       (dec),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule

FILE: rtl/sed_checker.sv
// ----------------------------------------------------------------------------
// sed_checker
// Port-level checks for the string escape decoder.
// ----------------------------------------------------------------------------
module sed_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [sed_pkg::CHAR_W-1:0] in_char_code,
  input logic                       in_first,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [sed_pkg::CHAR_W-1:0] out_char,
  input logic                       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result beat dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_char) && $stable(out_last))
    else $error("stalled result beat changed");

  a_first_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_first && (in_char_code != sed_pkg::CH_BSL)
    |=> out_valid)
    else $error("first byte gave no result");

  a_last_nul: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_char == sed_pkg::CH_NUL)
    else $error("last beat not NUL");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result after reset");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_char_code (in_char_code),
  .in_first     (in_first),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_char     (out_char),
  .out_last     (out_last)
);
